### sv/lpdh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpdh_pkg: shared types and constants for the length-prefixed deframer
// Word opcodes, result kinds, register indexes and the result record.
// ----------------------------------------------------------------------------
package lpdh_pkg;

  typedef enum logic [1:0] {
    OP_BYTE = 2'd0,
    OP_TICK = 2'd1,
    OP_SENT = 2'd2
  } opcode_t;

  typedef enum logic [2:0] {
    KIND_DATA      = 3'd0,
    KIND_EMPTY     = 3'd1,
    KIND_HEARTBEAT = 3'd2,
    KIND_OVERSIZE  = 3'd3,
    KIND_TIMEOUT   = 3'd4
  } kind_t;

  typedef enum logic {
    REG_MAX_PAYLOAD   = 1'b0,
    REG_TIMEOUT_TICKS = 1'b1
  } reg_index_t;

  localparam logic [2:0]  HDR_LAST    = 3'd3;
  localparam logic [2:0]  HDR_PAYLOAD = 3'd4;
  localparam logic [15:0] CNT_MAX     = 16'hFFFF;

  localparam logic [31:0] MAX_PAYLOAD_RESET   = 32'd8188;
  localparam logic [15:0] TIMEOUT_TICKS_RESET = 16'd30;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] payload_byte;
    logic       frame_end;
  } result_t;

endpackage

### sv/lpdh_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpdh_core: framing state, watchdog and heartbeat timers
// Updates all state for one accepted word and forms at most one result.
// ----------------------------------------------------------------------------
module lpdh_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_accept,
  input  logic [1:0]           opcode,
  input  logic [7:0]           rx_byte,
  input  logic                 wr_en,
  input  logic                 wr_index,
  input  logic [31:0]          wr_data,
  output logic                 res_valid,
  output lpdh_pkg::result_t    res
);

  logic [31:0] max_payload;
  logic [15:0] timeout_ticks;

  logic [2:0]  header_count,     header_count_next;
  logic [31:0] length_shift,     length_shift_next;
  logic [31:0] payload_left,     payload_left_next;
  logic [15:0] silence_count,    silence_count_next;
  logic [15:0] since_send_count, since_send_count_next;
  logic        disconnected,     disconnected_next;

  logic [31:0] len_val;
  logic [15:0] silence_inc;
  logic [15:0] since_send_inc;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload   <= lpdh_pkg::MAX_PAYLOAD_RESET;
      timeout_ticks <= lpdh_pkg::TIMEOUT_TICKS_RESET;
    end else if (wr_en) begin
      unique case (lpdh_pkg::reg_index_t'(wr_index))
        lpdh_pkg::REG_MAX_PAYLOAD:   max_payload   <= wr_data;
        lpdh_pkg::REG_TIMEOUT_TICKS: timeout_ticks <= wr_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_count     <= '0;
      length_shift     <= '0;
      payload_left     <= '0;
      silence_count    <= '0;
      since_send_count <= '0;
      disconnected     <= 1'b0;
    end else begin
      header_count     <= header_count_next;
      length_shift     <= length_shift_next;
      payload_left     <= payload_left_next;
      silence_count    <= silence_count_next;
      since_send_count <= since_send_count_next;
      disconnected     <= disconnected_next;
    end
  end

  assign silence_inc    = (silence_count == lpdh_pkg::CNT_MAX) ?
                          silence_count : silence_count + 16'd1;
  assign since_send_inc = (since_send_count == lpdh_pkg::CNT_MAX) ?
                          since_send_count : since_send_count + 16'd1;
  assign len_val        = (header_count == 3'd0) ? {24'd0, rx_byte} :
                          {length_shift[23:0], rx_byte};

  always_comb begin
    header_count_next     = header_count;
    length_shift_next     = length_shift;
    payload_left_next     = payload_left;
    silence_count_next    = silence_count;
    since_send_count_next = since_send_count;
    disconnected_next     = disconnected;
    res_valid             = 1'b0;
    res                   = '0;

    // Once disconnected, every word is dropped until reset.
    if (item_accept && !disconnected) begin
      unique case (lpdh_pkg::opcode_t'(opcode))
        lpdh_pkg::OP_BYTE: begin
          silence_count_next = '0;
          if (header_count < lpdh_pkg::HDR_PAYLOAD) begin
            length_shift_next = len_val;
            header_count_next = header_count + 3'd1;
            if (header_count == lpdh_pkg::HDR_LAST) begin
              if (len_val > max_payload) begin
                disconnected_next = 1'b1;
                res_valid         = 1'b1;
                res.kind          = lpdh_pkg::KIND_OVERSIZE;
              end else if (len_val == 32'd0) begin
                header_count_next = '0;
                res_valid         = 1'b1;
                res.kind          = lpdh_pkg::KIND_EMPTY;
                res.frame_end     = 1'b1;
              end else begin
                payload_left_next = len_val;
              end
            end
          end else begin
            payload_left_next = payload_left - 32'd1;
            res_valid         = 1'b1;
            res.kind          = lpdh_pkg::KIND_DATA;
            res.payload_byte  = rx_byte;
            if (payload_left == 32'd1) begin
              header_count_next = '0;
              length_shift_next = '0;
              res.frame_end     = 1'b1;
            end
          end
        end
        lpdh_pkg::OP_TICK: begin
          silence_count_next    = silence_inc;
          since_send_count_next = since_send_inc;
          // The watchdog takes precedence over the heartbeat on the same tick.
          if (silence_inc >= timeout_ticks) begin
            disconnected_next = 1'b1;
            res_valid         = 1'b1;
            res.kind          = lpdh_pkg::KIND_TIMEOUT;
          end else if (since_send_inc >= {1'b0, timeout_ticks[15:1]}) begin
            since_send_count_next = '0;
            res_valid             = 1'b1;
            res.kind              = lpdh_pkg::KIND_HEARTBEAT;
          end
        end
        lpdh_pkg::OP_SENT: begin
          since_send_count_next = '0;
        end
        default: ;
      endcase
    end
  end

endmodule

### sv/length_prefixed_deframer_heartbeat.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// length_prefixed_deframer_heartbeat: stream deframer with watchdog
// Top level: framing core plus a two-entry output buffer.
// ----------------------------------------------------------------------------
// Input words carry an opcode (received byte, time tick, packet sent) and a
// byte. Each byte stream frame is a 4-byte big-endian length and its payload;
// payload bytes come out one result word each, the last with frame_end set.
// A zero-length frame gives an empty-frame word, a length above max_payload
// an oversize disconnect. Ticks drive the receive watchdog (timeout
// disconnect) and the heartbeat request timer. After a disconnect all input
// words are taken and dropped until reset.
// Both channels use valid/stall. One input word is taken per cycle while
// in_stall is low; each result is registered in the output register, or in
// the skid register while the output is held. The two registers hold up to
// two results, so in_stall rises only when the skid register is full and
// comes from a register. Reset clears framing state and timers, loads
// max_payload 8188 and timeout_ticks 30, and empties both output registers.
// Registers are written through wr_en/wr_index/wr_data by the user only while idle; not enforced.
// ----------------------------------------------------------------------------
module length_prefixed_deframer_heartbeat (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  opcode,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  kind,
  output logic [7:0]  payload_byte,
  output logic        frame_end,
  input  logic        wr_en,
  input  logic        wr_index,
  input  logic [31:0] wr_data
);

  logic              item_accept;
  logic              res_valid;
  lpdh_pkg::result_t res;
  lpdh_pkg::result_t out_word;
  lpdh_pkg::result_t skid_word;
  logic              skid_valid;
  logic              out_take;

  assign in_stall    = skid_valid;
  assign item_accept = in_valid && !skid_valid;
  assign out_take    = out_valid && !out_stall;

  lpdh_core u_core (
    .clk         (clk),
    .rst         (rst),
    .item_accept (item_accept),
    .opcode      (opcode),
    .rx_byte     (rx_byte),
    .wr_en       (wr_en),
    .wr_index    (wr_index),
    .wr_data     (wr_data),
    .res_valid   (res_valid),
    .res         (res)
  );

  // New results enter only while the skid register is empty.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (skid_valid) begin
        if (out_take) begin
          out_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end
      end else if (res_valid) begin
        if (!out_valid || out_take) begin
          out_valid <= 1'b1;
        end else begin
          skid_valid <= 1'b1;
        end
      end else if (out_take) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_take) begin
        out_word <= skid_word;
      end
    end else if (res_valid) begin
      if (!out_valid || out_take) begin
        out_word <= res;
      end else begin
        skid_word <= res;
      end
    end
  end

  assign kind         = out_word.kind;
  assign payload_byte = out_word.payload_byte;
  assign frame_end    = out_word.frame_end;

endmodule

### sv/lpdh_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpdh_checker: port-level checks for the deframer
// Watches the top-level ports and is bound to every instance of it.
// ----------------------------------------------------------------------------
module lpdh_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [2:0] kind,
  input logic [7:0] payload_byte,
  input logic       frame_end
);

  // A word held by the receiver stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(kind) &&
      $stable(payload_byte) && $stable(frame_end))
    else $error("output word changed while stalled");

  // Only payload words carry a byte; only payload and empty-frame words end a frame.
  a_field_rules: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != lpdh_pkg::KIND_DATA |->
      payload_byte == 8'd0 &&
      (frame_end == 1'b0 || kind == lpdh_pkg::KIND_EMPTY))
    else $error("result fields inconsistent with kind");

  // A disconnect is the final word until reset.
  a_disc_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall &&
      (kind == lpdh_pkg::KIND_OVERSIZE || kind == lpdh_pkg::KIND_TIMEOUT)
      |=> !out_valid)
    else $error("word delivered after a disconnect");

  // Reset leaves both sides free and nothing pending.
  a_reset_clear: assert property (@(posedge clk)
    $past(rst) |-> !out_valid && !in_stall)
    else $error("buffers not empty after reset");

endmodule

bind length_prefixed_deframer_heartbeat lpdh_checker u_lpdh_checker (
  .clk          (clk),
  .rst          (rst),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .kind         (kind),
  .payload_byte (payload_byte),
  .frame_end    (frame_end)
);
